// ----- src/m3inv_pkg.sv -----
package m3inv_pkg;

	localparam int EW = 32;
	localparam int FB = 16;
	localparam int PW = 2 * EW;
	localparam int CW = 2 * EW + 1;
	localparam int DETW = 3 * EW + 1;
	localparam int DW = 3 * EW;
	localparam int NW = 2 * EW + 2 * FB;
	localparam int NDIV = NW;
	localparam int LANES = 9;
	localparam int TERMS = 6;

	localparam longint MAXP = (longint'(1) <<< (EW - 1)) - 1;
	localparam bit ONE_FITS = (FB < EW - 1);
	localparam logic [EW-1:0] ONE_V = ONE_FITS ? EW'(longint'(1) <<< FB) : EW'(MAXP);

	// cofactor l = a[p]*a[q] - a[r]*a[s], indexes row-major from 0
	localparam int COF_P [LANES] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int COF_Q [LANES] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int COF_R [LANES] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int COF_S [LANES] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	// Sarrus terms, first three added, last three subtracted
	localparam int DET_A [TERMS] = '{0, 3, 6, 6, 3, 0};
	localparam int DET_B [TERMS] = '{4, 7, 1, 4, 1, 7};
	localparam int DET_C [TERMS] = '{8, 2, 5, 2, 8, 5};

	typedef struct packed {
		logic signed [EW-1:0] a11;
		logic signed [EW-1:0] a12;
		logic signed [EW-1:0] a13;
		logic signed [EW-1:0] a21;
		logic signed [EW-1:0] a22;
		logic signed [EW-1:0] a23;
		logic signed [EW-1:0] a31;
		logic signed [EW-1:0] a32;
		logic signed [EW-1:0] a33;
	} m3inv_in_t;

	typedef struct packed {
		logic signed [EW-1:0] r11;
		logic signed [EW-1:0] r12;
		logic signed [EW-1:0] r13;
		logic signed [EW-1:0] r21;
		logic signed [EW-1:0] r22;
		logic signed [EW-1:0] r23;
		logic signed [EW-1:0] r31;
		logic signed [EW-1:0] r32;
		logic signed [EW-1:0] r33;
		logic singular;
		logic overflowed;
	} m3inv_out_t;

	typedef struct packed {
		logic singular;
		logic [LANES-1:0] neg;
	} m3inv_side_t;

endpackage

// ----- src/m3inv_front.sv -----
module m3inv_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  m3inv_pkg::m3inv_in_t word_in,
	output logic v_out,
	output m3inv_pkg::m3inv_side_t side_out,
	output logic [m3inv_pkg::DW-1:0] d_out,
	output logic [m3inv_pkg::NW-1:0] n_out [m3inv_pkg::LANES]
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [m3inv_pkg::EW-1:0] a_s1 [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::PW-1:0] pp_s2 [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::PW-1:0] pq_s2 [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::PW-1:0] pd_s2 [m3inv_pkg::TERMS];
	logic signed [m3inv_pkg::EW-1:0] c3_s2 [m3inv_pkg::TERMS];
	logic signed [m3inv_pkg::CW-1:0] cof_s3 [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::PW:0] tlo_s3 [m3inv_pkg::TERMS];
	logic signed [m3inv_pkg::PW-1:0] thi_s3 [m3inv_pkg::TERMS];
	logic signed [m3inv_pkg::CW-1:0] cof_s4 [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::DETW-1:0] trip_s4 [m3inv_pkg::TERMS];
	logic signed [m3inv_pkg::CW-1:0] cof_s5 [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::DETW-1:0] sp_s5, sn_s5;
	logic signed [m3inv_pkg::CW-1:0] cof_s6 [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::DETW-1:0] det_s6;
	logic [m3inv_pkg::DW-1:0] d_s7;
	logic [m3inv_pkg::NW-1:0] n_s7 [m3inv_pkg::LANES];
	m3inv_pkg::m3inv_side_t side_s7;

	logic signed [m3inv_pkg::EW-1:0] a_in [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::CW-1:0] cabs [m3inv_pkg::LANES];
	logic signed [m3inv_pkg::DETW-1:0] dabs;

	assign a_in[0] = word_in.a11;
	assign a_in[1] = word_in.a12;
	assign a_in[2] = word_in.a13;
	assign a_in[3] = word_in.a21;
	assign a_in[4] = word_in.a22;
	assign a_in[5] = word_in.a23;
	assign a_in[6] = word_in.a31;
	assign a_in[7] = word_in.a32;
	assign a_in[8] = word_in.a33;

	always_comb begin
		for (int l = 0; l < m3inv_pkg::LANES; l++) begin
			cabs[l] = cof_s6[l][m3inv_pkg::CW-1] ? -cof_s6[l] : cof_s6[l];
		end
		dabs = det_s6[m3inv_pkg::DETW-1] ? -det_s6 : det_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < m3inv_pkg::LANES; l++) begin
				a_s1[l] <= a_in[l];
				pp_s2[l] <= a_s1[m3inv_pkg::COF_P[l]] * a_s1[m3inv_pkg::COF_Q[l]];
				pq_s2[l] <= a_s1[m3inv_pkg::COF_R[l]] * a_s1[m3inv_pkg::COF_S[l]];
				cof_s3[l] <= m3inv_pkg::CW'(pp_s2[l]) - m3inv_pkg::CW'(pq_s2[l]);
				cof_s4[l] <= cof_s3[l];
				cof_s5[l] <= cof_s4[l];
				cof_s6[l] <= cof_s5[l];
				n_s7[l] <= {cabs[l][m3inv_pkg::PW-1:0], {(2 * m3inv_pkg::FB){1'b0}}};
				side_s7.neg[l] <= cof_s6[l][m3inv_pkg::CW-1] ^ det_s6[m3inv_pkg::DETW-1];
			end
			for (int j = 0; j < m3inv_pkg::TERMS; j++) begin
				pd_s2[j] <= a_s1[m3inv_pkg::DET_A[j]] * a_s1[m3inv_pkg::DET_B[j]];
				c3_s2[j] <= a_s1[m3inv_pkg::DET_C[j]];
				tlo_s3[j] <= $signed({1'b0, pd_s2[j][m3inv_pkg::EW-1:0]}) * c3_s2[j];
				thi_s3[j] <= $signed(pd_s2[j][m3inv_pkg::PW-1:m3inv_pkg::EW]) * c3_s2[j];
				trip_s4[j] <= (m3inv_pkg::DETW'(thi_s3[j]) <<< m3inv_pkg::EW)
					+ m3inv_pkg::DETW'(tlo_s3[j]);
			end
			sp_s5 <= trip_s4[0] + trip_s4[1] + trip_s4[2];
			sn_s5 <= trip_s4[3] + trip_s4[4] + trip_s4[5];
			det_s6 <= sp_s5 - sn_s5;
			d_s7 <= dabs[m3inv_pkg::DW-1:0];
			side_s7.singular <= (det_s6 == '0);
		end
	end

	assign v_out = v_s7;
	assign side_out = side_s7;
	assign d_out = d_s7;
	assign n_out = n_s7;

endmodule

// ----- src/m3inv_divider.sv -----
module m3inv_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  m3inv_pkg::m3inv_side_t side_in,
	input  logic [m3inv_pkg::DW-1:0] d_in,
	input  logic [m3inv_pkg::NW-1:0] n_in [m3inv_pkg::LANES],
	output logic v_out,
	output m3inv_pkg::m3inv_side_t side_out,
	output logic [m3inv_pkg::DW-1:0] d_out,
	output logic [m3inv_pkg::NW-1:0] q_out [m3inv_pkg::LANES],
	output logic [m3inv_pkg::DW-1:0] rem_out [m3inv_pkg::LANES]
);

	localparam int N = m3inv_pkg::NDIV;

	logic [N-1:0] v_s;
	m3inv_pkg::m3inv_side_t side_s [N];
	logic [m3inv_pkg::DW-1:0] d_s [N];
	logic [m3inv_pkg::NW-1:0] nq_s [N][m3inv_pkg::LANES];
	logic [m3inv_pkg::DW-1:0] rem_s [N][m3inv_pkg::LANES];

	logic [m3inv_pkg::DW-1:0] d_src [N];
	logic [m3inv_pkg::NW-1:0] nq_src [N][m3inv_pkg::LANES];
	logic [m3inv_pkg::DW-1:0] rem_src [N][m3inv_pkg::LANES];
	logic [m3inv_pkg::DW:0] trial [N][m3inv_pkg::LANES];
	logic ge [N][m3inv_pkg::LANES];
	logic [m3inv_pkg::NW-1:0] nq_nx [N][m3inv_pkg::LANES];
	logic [m3inv_pkg::DW-1:0] rem_nx [N][m3inv_pkg::LANES];

	always_comb begin
		d_src[0] = d_in;
		for (int l = 0; l < m3inv_pkg::LANES; l++) begin
			nq_src[0][l] = n_in[l];
			rem_src[0][l] = '0;
		end
		for (int k = 1; k < N; k++) begin
			d_src[k] = d_s[k-1];
			for (int l = 0; l < m3inv_pkg::LANES; l++) begin
				nq_src[k][l] = nq_s[k-1][l];
				rem_src[k][l] = rem_s[k-1][l];
			end
		end
		for (int k = 0; k < N; k++) begin
			for (int l = 0; l < m3inv_pkg::LANES; l++) begin
				trial[k][l] = {rem_src[k][l], nq_src[k][l][m3inv_pkg::NW-1]};
				ge[k][l] = trial[k][l] >= {1'b0, d_src[k]};
				rem_nx[k][l] = ge[k][l]
					? m3inv_pkg::DW'(trial[k][l] - {1'b0, d_src[k]})
					: trial[k][l][m3inv_pkg::DW-1:0];
				nq_nx[k][l] = {nq_src[k][l][m3inv_pkg::NW-2:0], ge[k][l]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-2:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < N; k++) begin
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < N; k++) begin
				d_s[k] <= d_src[k];
				for (int l = 0; l < m3inv_pkg::LANES; l++) begin
					nq_s[k][l] <= nq_nx[k][l];
					rem_s[k][l] <= rem_nx[k][l];
				end
			end
		end
	end

	assign v_out = v_s[N-1];
	assign side_out = side_s[N-1];
	assign d_out = d_s[N-1];
	assign q_out = nq_s[N-1];
	assign rem_out = rem_s[N-1];

endmodule

// ----- src/m3inv_round.sv -----
module m3inv_round (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  m3inv_pkg::m3inv_side_t side_in,
	input  logic [m3inv_pkg::DW-1:0] d_in,
	input  logic [m3inv_pkg::NW-1:0] q_in [m3inv_pkg::LANES],
	input  logic [m3inv_pkg::DW-1:0] rem_in [m3inv_pkg::LANES],
	output logic v_out,
	output m3inv_pkg::m3inv_out_t word_out
);

	logic v_s1;
	m3inv_pkg::m3inv_out_t word_s1;

	logic inc [m3inv_pkg::LANES];
	logic [m3inv_pkg::NW:0] q1 [m3inv_pkg::LANES];
	logic [m3inv_pkg::NW:0] lim [m3inv_pkg::LANES];
	logic sat [m3inv_pkg::LANES];
	logic [m3inv_pkg::EW-1:0] mag [m3inv_pkg::LANES];
	logic [m3inv_pkg::EW-1:0] val [m3inv_pkg::LANES];
	logic ov_any;
	m3inv_pkg::m3inv_out_t word_nx;

	always_comb begin
		ov_any = 1'b0;
		for (int l = 0; l < m3inv_pkg::LANES; l++) begin
			inc[l] = {rem_in[l], 1'b0} >= {1'b0, d_in};
			q1[l] = {1'b0, q_in[l]} + (m3inv_pkg::NW + 1)'(inc[l]);
			lim[l] = ((m3inv_pkg::NW + 1)'(1) << (m3inv_pkg::EW - 1))
				- (m3inv_pkg::NW + 1)'(!side_in.neg[l]);
			sat[l] = q1[l] > lim[l];
			mag[l] = sat[l] ? lim[l][m3inv_pkg::EW-1:0] : q1[l][m3inv_pkg::EW-1:0];
			val[l] = side_in.neg[l] ? -mag[l] : mag[l];
			ov_any = ov_any | sat[l];
		end
		if (side_in.singular) begin
			word_nx = '0;
			word_nx.r11 = m3inv_pkg::ONE_V;
			word_nx.r22 = m3inv_pkg::ONE_V;
			word_nx.r33 = m3inv_pkg::ONE_V;
			word_nx.singular = 1'b1;
			word_nx.overflowed = !m3inv_pkg::ONE_FITS;
		end else begin
			word_nx.r11 = val[0];
			word_nx.r12 = val[1];
			word_nx.r13 = val[2];
			word_nx.r21 = val[3];
			word_nx.r22 = val[4];
			word_nx.r23 = val[5];
			word_nx.r31 = val[6];
			word_nx.r32 = val[7];
			word_nx.r33 = val[8];
			word_nx.singular = 1'b0;
			word_nx.overflowed = ov_any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= word_nx;
		end
	end

	assign v_out = v_s1;
	assign word_out = word_s1;

endmodule

// ----- src/matrix3x3_inverse_unit.sv -----
// channel   | word         | handshake
// ----------+--------------+------------------------------
// matrix    | m3inv_in_t   | matrix_valid / matrix_stall
// inverse   | m3inv_out_t  | inverse_valid / inverse_stall
//
// One word enters per cycle while matrix_stall is low; at Q16.16 the path runs
// through the bit-per-stage restoring divider, one stage per quotient bit.
// arst_n clears all valid bits at once; payload registers are not reset.
// The pipeline advances as a whole; it holds while a result waits under
// inverse_stall, and matrix_stall is raised for exactly those cycles.
module matrix3x3_inverse_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic matrix_valid,
	output logic matrix_stall,
	input  m3inv_pkg::m3inv_in_t matrix,
	output logic inverse_valid,
	input  logic inverse_stall,
	output m3inv_pkg::m3inv_out_t inverse
);

	logic en;

	logic f_v;
	m3inv_pkg::m3inv_side_t f_side;
	logic [m3inv_pkg::DW-1:0] f_d;
	logic [m3inv_pkg::NW-1:0] f_n [m3inv_pkg::LANES];

	logic q_v;
	m3inv_pkg::m3inv_side_t q_side;
	logic [m3inv_pkg::DW-1:0] q_d;
	logic [m3inv_pkg::NW-1:0] q_q [m3inv_pkg::LANES];
	logic [m3inv_pkg::DW-1:0] q_rem [m3inv_pkg::LANES];

	assign en = !(inverse_valid && inverse_stall);
	assign matrix_stall = !en;

	m3inv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (matrix_valid),
		.word_in  (matrix),
		.v_out    (f_v),
		.side_out (f_side),
		.d_out    (f_d),
		.n_out    (f_n)
	);

	m3inv_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (f_v),
		.side_in  (f_side),
		.d_in     (f_d),
		.n_in     (f_n),
		.v_out    (q_v),
		.side_out (q_side),
		.d_out    (q_d),
		.q_out    (q_q),
		.rem_out  (q_rem)
	);

	m3inv_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (q_v),
		.side_in  (q_side),
		.d_in     (q_d),
		.q_in     (q_q),
		.rem_in   (q_rem),
		.v_out    (inverse_valid),
		.word_out (inverse)
	);

endmodule

// ----- src/m3inv_checker.sv -----
module m3inv_checker (
	input logic clk,
	input logic arst_n,
	input logic matrix_stall,
	input logic inverse_valid,
	input logic inverse_stall,
	input m3inv_pkg::m3inv_out_t inverse
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !inverse_valid)
		else $error("result valid during reset");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		matrix_stall == (inverse_valid && inverse_stall))
		else $error("input stall not tied to blocked output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inverse_valid && inverse_stall |=> inverse_valid && $stable(inverse))
		else $error("stalled result word changed");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		inverse_valid && inverse.singular |->
			inverse.r12 == '0 && inverse.r13 == '0 && inverse.r21 == '0 &&
			inverse.r23 == '0 && inverse.r31 == '0 && inverse.r32 == '0 &&
			inverse.r11 == m3inv_pkg::ONE_V && inverse.r22 == m3inv_pkg::ONE_V &&
			inverse.r33 == m3inv_pkg::ONE_V)
		else $error("singular result is not the identity");

endmodule

bind matrix3x3_inverse_unit m3inv_checker u_chk (.*);
